[rtl/fcss_pkg.sv]
// Package for the filled circle span stepper: field widths, action codes,
// circle state and span job types. No dependencies.
package fcss_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned RadiusW = 7;
  localparam int unsigned DecW    = 12;
  localparam int unsigned SpanW   = 10;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned PaddrW   = 3;

  localparam logic [1:0] SlotLast = 2'd3;
  localparam logic [0:0] RegFillColor = 1'b0;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DecW-1:0]   d;
    logic              active;
  } circ_state_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              done;
  } span_job_t;

endpackage

[rtl/fcss_octant_step.sv]
// Midpoint decision update for one input item: start load or octant step.
// Depends on fcss_pkg.
module fcss_octant_step
  import fcss_pkg::*;
(
  input  circ_state_t        state_i,
  input  action_e            action_i,
  input  logic [CoordW-1:0]  center_x_i,
  input  logic [CoordW-1:0]  center_y_i,
  input  logic [RadiusW-1:0] radius_i,
  output circ_state_t        state_o,
  output logic               emit_o,
  output span_job_t          job_o
);

  logic [CoordW-1:0] x_inc;
  logic [CoordW-1:0] y_dec;
  logic [CoordW-1:0] y_new;
  logic [DecW-1:0]   x_ext;
  logic [DecW-1:0]   y_ext;
  logic [DecW-1:0]   r_ext;
  logic [DecW-1:0]   d_new;
  logic              done;

  always_comb begin
    x_inc = state_i.x + CoordW'(1);
    y_dec = state_i.y - CoordW'(1);
    x_ext = {{(DecW-CoordW){1'b0}}, x_inc};
    r_ext = {{(DecW-RadiusW){1'b0}}, radius_i};
    if ($signed(state_i.d) > $signed(DecW'(0))) begin
      y_new = y_dec;
      y_ext = {{(DecW-CoordW){y_dec[CoordW-1]}}, y_dec};
      d_new = state_i.d + ((x_ext - y_ext) << 2) + DecW'(10);
    end else begin
      y_new = state_i.y;
      y_ext = {{(DecW-CoordW){state_i.y[CoordW-1]}}, state_i.y};
      d_new = state_i.d + (x_ext << 2) + DecW'(6);
    end
    done = $signed({y_new[CoordW-1], y_new}) < $signed({1'b0, x_inc});

    state_o = state_i;
    emit_o  = 1'b0;
    job_o   = '0;
    case (action_i)
      ACT_START: begin
        state_o.cx     = center_x_i;
        state_o.cy     = center_y_i;
        state_o.x      = '0;
        state_o.y      = {1'b0, radius_i};
        state_o.d      = DecW'(3) - (r_ext << 1);
        state_o.active = 1'b1;
        emit_o         = 1'b1;
        job_o          = '{cx: center_x_i, cy: center_y_i, x: '0,
                           y: {1'b0, radius_i}, done: 1'b0};
      end
      ACT_STEP: begin
        if (state_i.active) begin
          state_o.x      = x_inc;
          state_o.y      = y_new;
          state_o.d      = d_new;
          state_o.active = !done;
          emit_o         = 1'b1;
          job_o          = '{cx: state_i.cx, cy: state_i.cy, x: x_inc,
                             y: y_new, done: done};
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

[rtl/filled_circle_span_stepper.sv]
// Top level of the filled circle span stepper: input stream, APB register,
// circle state, span job buffer and span output. Depends on fcss_pkg and
// fcss_octant_step.
//
// Usage: each input transfer carries an action in s_axis_tuser (start or
// step) and center/radius in s_axis_tdata. A start, or a step while a
// circle is in progress, yields four span transfers on the master side;
// the fourth has tlast set and carries circle_done in tuser on the step
// where y fell below x. A step with no circle in progress yields nothing.
// The circle state updates at the input transfer; the four spans are then
// read out of a one-entry job buffer, one per cycle while the receiver is
// ready, so the first span appears the cycle after the input transfer. The
// next input is taken in the cycle of the last span transfer, so a new item
// is accepted only as the previous one finishes its spans.
// fill_color is written through APB at addresses 0 to 3 (paddr[2] clear;
// pready is always high). Reset clears the color, the circle state and the
// job valid flag, but not the buffered job data. When the receiver stalls,
// the current span holds and input is held off once the job buffer is full.
module filled_circle_span_stepper
  import fcss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // center_x [7:0], center_y [15:8], radius [22:16], zero [23]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action [0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // span_left [9:0], span_right [19:10], span_row [29:20],
  // span_color [45:30], zero [47:46]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // circle_done [0]
  output logic                m_axis_tuser
);

  logic [ColorW-1:0] color_q;
  circ_state_t       state_q, state_d;
  span_job_t         job_q, job_d;
  logic              job_valid_q;
  logic [1:0]        cnt_q;
  logic              emit;
  logic              in_xfer, out_xfer, out_last;
  logic              cfg_wr;
  logic [SpanW-1:0]  cx10, cy10, x10, y10;
  logic [SpanW-1:0]  span_left, span_right, span_row;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PaddrW-1] == RegFillColor) ?
                  {{(32-ColorW){1'b0}}, color_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else if (cfg_wr && paddr[PaddrW-1] == RegFillColor) begin
      color_q <= pwdata[ColorW-1:0];
    end
  end

  fcss_octant_step u_step (
    .state_i    (state_q),
    .action_i   (action_e'(s_axis_tuser)),
    .center_x_i (s_axis_tdata[7:0]),
    .center_y_i (s_axis_tdata[15:8]),
    .radius_i   (s_axis_tdata[22:16]),
    .state_o    (state_d),
    .emit_o     (emit),
    .job_o      (job_d)
  );

  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign out_last      = out_xfer && cnt_q == SlotLast;
  assign s_axis_tready = !job_valid_q || out_last;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer && emit) begin
        job_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (out_last) begin
        job_valid_q <= 1'b0;
        cnt_q       <= '0;
      end else if (out_xfer) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      job_q <= job_d;
    end
  end

  always_comb begin
    cx10 = {2'b00, job_q.cx};
    cy10 = {2'b00, job_q.cy};
    x10  = {2'b00, job_q.x};
    y10  = {{(SpanW-CoordW){job_q.y[CoordW-1]}}, job_q.y};
    case (cnt_q)
      2'd0: begin
        span_left  = cx10 - x10;
        span_right = cx10 + x10;
        span_row   = cy10 + y10;
      end
      2'd1: begin
        span_left  = cx10 - x10;
        span_right = cx10 + x10;
        span_row   = cy10 - y10;
      end
      2'd2: begin
        span_left  = cx10 - y10;
        span_right = cx10 + y10;
        span_row   = cy10 + x10;
      end
      default: begin
        span_left  = cx10 - y10;
        span_right = cx10 + y10;
        span_row   = cy10 - x10;
      end
    endcase
  end

  assign m_axis_tvalid = job_valid_q;
  assign m_axis_tdata  = {2'b00, color_q, span_row, span_right, span_left};
  assign m_axis_tlast  = cnt_q == SlotLast;
  assign m_axis_tuser  = job_q.done && cnt_q == SlotLast;

  a_in_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!job_valid_q || out_last))
    else $error("input transfer while span job still pending");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_last && !in_xfer) |=> !m_axis_tvalid)
    else $error("spans continue after last span transfer");

  a_cnt_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> job_valid_q)
    else $error("span counter advanced with no job");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("circle done flagged on non-final span");

endmodule
